### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers; empty for synthesis.
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/msdemux_pkg.sv
`timescale 1ns / 1ps

package msdemux_pkg;

    localparam int QDEPTH_DEF = 2;

    localparam logic [23:0] CODE_PREFIX   = 24'h000001;
    localparam logic [23:0] WINDOW_IDLE   = 24'hFFFFFF;
    localparam logic [7:0]  CODE_END      = 8'hB9;
    localparam logic [7:0]  CODE_PACK     = 8'hBA;
    localparam logic [7:0]  CODE_SYSHDR   = 8'hBB;
    localparam logic [15:0] PACK_LEN      = 16'd8;
    localparam logic [3:0]  SYS_FIXED_LEN = 4'd6;
    localparam logic [3:0]  TS_PTS_LEN    = 4'd4;
    localparam logic [3:0]  TS_BOTH_LEN   = 4'd9;
    localparam logic [3:0]  TS_PTS_MARK   = 4'h2;
    localparam logic [3:0]  TS_BOTH_MARK  = 4'h3;

    typedef enum logic [4:0] {
        PH_SEARCH      = 5'd0,
        PH_PACK        = 5'd1,
        PH_SYS_LEN_HI  = 5'd2,
        PH_SYS_LEN_LO  = 5'd3,
        PH_SYS_FIXED   = 5'd4,
        PH_SYS_ID      = 5'd5,
        PH_SYS_STD1    = 5'd6,
        PH_SYS_STD2    = 5'd7,
        PH_SYS_SKIP    = 5'd8,
        PH_PKT_LEN_HI  = 5'd9,
        PH_PKT_LEN_LO  = 5'd10,
        PH_PKT_FLAGS   = 5'd11,
        PH_PKT_STD     = 5'd12,
        PH_PKT_TS_CHK  = 5'd13,
        PH_PKT_TS_SKIP = 5'd14,
        PH_PKT_DISCARD = 5'd15,
        PH_PKT_VIDEO   = 5'd16,
        PH_PKT_AUDIO   = 5'd17,
        PH_ENDED       = 5'd18
    } t_phase;

    typedef enum logic [3:0] {
        KIND_SEARCH = 4'd0,
        KIND_CODE   = 4'd1,
        KIND_PACK   = 4'd2,
        KIND_SYSHDR = 4'd3,
        KIND_PKTHDR = 4'd4,
        KIND_STUFF  = 4'd5,
        KIND_VIDEO  = 4'd6,
        KIND_AUDIO  = 4'd7,
        KIND_SKIP   = 4'd8,
        KIND_ENDED  = 4'd9
    } t_kind;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        t_kind      byte_kind;
        logic [7:0] packet_stream_id;
        logic       last_of_packet;
        logic       stream_ended;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### src/msdemux_parser.sv
`timescale 1ns / 1ps

module msdemux_parser import msdemux_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  t_q_status  i_q_stat,
    output logic       o_push,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_window, n_window;
    logic [15:0] r_btg, n_btg;
    logic [3:0]  r_hu, n_hu;
    logic [7:0]  r_cur_id, n_cur_id;
    logic [7:0]  r_aud_id, n_aud_id;
    logic        r_aud_set, n_aud_set;
    logic [7:0]  r_vid_id, n_vid_id;
    logic        r_vid_set, n_vid_set;

    logic        accept;
    logic [15:0] btg_dec;
    logic [3:0]  hu_dec;
    logic [3:0]  hu_inc;
    logic        cur_video;
    logic        cur_audio;
    t_phase      pay_phase;
    t_phase      ts_phase;
    logic [3:0]  ts_hu;
    logic        valid;
    t_kind       kind;
    logic [7:0]  pid;
    logic        last;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        btg_dec   = (r_btg != 16'd0) ? r_btg - 16'd1 : 16'd0;
        hu_dec    = (r_hu != 4'd0) ? r_hu - 4'd1 : 4'd0;
        hu_inc    = r_hu + 4'd1;
        cur_video = r_vid_set && (r_cur_id == r_vid_id);
        cur_audio = r_aud_set && (r_cur_id == r_aud_id);
        // payload entry, after this byte has been counted
        if (btg_dec == 16'd0) begin
            pay_phase = PH_SEARCH;
        end else if (cur_video) begin
            pay_phase = PH_PKT_VIDEO;
        end else begin
            pay_phase = PH_PKT_AUDIO;
        end
        ts_hu = r_hu;
        if (i_byte[7:4] == TS_PTS_MARK) begin
            ts_phase = PH_PKT_TS_SKIP;
            ts_hu    = TS_PTS_LEN;
        end else if (i_byte[7:4] == TS_BOTH_MARK) begin
            ts_phase = PH_PKT_TS_SKIP;
            ts_hu    = TS_BOTH_LEN;
        end else begin
            ts_phase = pay_phase;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_window  = r_window;
        n_btg     = r_btg;
        n_hu      = r_hu;
        n_cur_id  = r_cur_id;
        n_aud_id  = r_aud_id;
        n_aud_set = r_aud_set;
        n_vid_id  = r_vid_id;
        n_vid_set = r_vid_set;
        valid     = 1'b0;
        kind      = KIND_SEARCH;
        pid       = 8'd0;
        last      = 1'b0;

        case (r_phase)
            PH_ENDED: begin
                kind = KIND_ENDED;
            end
            PH_PACK: begin
                kind  = KIND_PACK;
                n_btg = btg_dec;
                if (btg_dec == 16'd0) n_phase = PH_SEARCH;
            end
            PH_SYS_LEN_HI: begin
                kind    = KIND_SYSHDR;
                n_btg   = {i_byte, 8'd0};
                n_phase = PH_SYS_LEN_LO;
            end
            PH_SYS_LEN_LO: begin
                kind    = KIND_SYSHDR;
                n_btg   = r_btg | {8'd0, i_byte};
                n_hu    = 4'd0;
                n_phase = ((r_btg | {8'd0, i_byte}) == 16'd0) ? PH_SEARCH : PH_SYS_FIXED;
            end
            PH_SYS_FIXED: begin
                kind    = KIND_SYSHDR;
                n_hu    = hu_inc;
                n_btg   = btg_dec;
                n_phase = (btg_dec == 16'd0) ? PH_SEARCH :
                          (hu_inc >= SYS_FIXED_LEN) ? PH_SYS_ID : PH_SYS_FIXED;
            end
            PH_SYS_ID: begin
                kind  = KIND_SYSHDR;
                n_btg = btg_dec;
                if (i_byte[7]) begin
                    if (i_byte[7:5] == 3'b110) begin
                        n_aud_id  = i_byte;
                        n_aud_set = 1'b1;
                    end else if (i_byte[7:4] == 4'hE) begin
                        // first video ID wins
                        if (!r_vid_set || r_vid_id == i_byte) begin
                            n_vid_id  = i_byte;
                            n_vid_set = 1'b1;
                        end
                    end
                    n_phase = (btg_dec == 16'd0) ? PH_SEARCH : PH_SYS_STD1;
                end else begin
                    n_phase = (btg_dec == 16'd0) ? PH_SEARCH : PH_SYS_SKIP;
                end
            end
            PH_SYS_STD1: begin
                kind    = KIND_SYSHDR;
                n_btg   = btg_dec;
                n_phase = (btg_dec == 16'd0) ? PH_SEARCH : PH_SYS_STD2;
            end
            PH_SYS_STD2: begin
                kind    = KIND_SYSHDR;
                n_btg   = btg_dec;
                n_phase = (btg_dec == 16'd0) ? PH_SEARCH : PH_SYS_ID;
            end
            PH_SYS_SKIP: begin
                kind    = KIND_SYSHDR;
                n_btg   = btg_dec;
                n_phase = (btg_dec == 16'd0) ? PH_SEARCH : PH_SYS_SKIP;
            end
            PH_PKT_LEN_HI: begin
                kind    = KIND_PKTHDR;
                pid     = r_cur_id;
                n_btg   = {i_byte, 8'd0};
                n_phase = PH_PKT_LEN_LO;
            end
            PH_PKT_LEN_LO: begin
                kind  = KIND_PKTHDR;
                pid   = r_cur_id;
                n_btg = r_btg | {8'd0, i_byte};
                if (cur_video || cur_audio) begin
                    n_phase = PH_PKT_FLAGS;
                end else begin
                    n_phase = ((r_btg | {8'd0, i_byte}) == 16'd0) ? PH_SEARCH :
                              PH_PKT_DISCARD;
                end
            end
            PH_PKT_FLAGS: begin
                pid   = r_cur_id;
                n_btg = btg_dec;
                if (i_byte[7]) begin
                    kind = KIND_STUFF;
                end else if (i_byte[7:6] == 2'b01) begin
                    kind    = KIND_PKTHDR;
                    n_phase = PH_PKT_STD;
                end else begin
                    kind    = KIND_PKTHDR;
                    n_hu    = ts_hu;
                    n_phase = ts_phase;
                end
            end
            PH_PKT_STD: begin
                kind    = KIND_PKTHDR;
                pid     = r_cur_id;
                n_btg   = btg_dec;
                n_phase = PH_PKT_TS_CHK;
            end
            PH_PKT_TS_CHK: begin
                kind    = KIND_PKTHDR;
                pid     = r_cur_id;
                n_btg   = btg_dec;
                n_hu    = ts_hu;
                n_phase = ts_phase;
            end
            PH_PKT_TS_SKIP: begin
                kind  = KIND_PKTHDR;
                pid   = r_cur_id;
                n_btg = btg_dec;
                n_hu  = hu_dec;
                if (hu_dec == 4'd0) n_phase = pay_phase;
            end
            PH_PKT_DISCARD, PH_PKT_VIDEO, PH_PKT_AUDIO: begin
                pid   = r_cur_id;
                valid = (r_phase == PH_PKT_VIDEO);
                kind  = (r_phase == PH_PKT_VIDEO) ? KIND_VIDEO :
                        (r_phase == PH_PKT_AUDIO) ? KIND_AUDIO : KIND_SKIP;
                n_btg = btg_dec;
                if (btg_dec == 16'd0) begin
                    last    = (r_phase == PH_PKT_VIDEO);
                    n_phase = PH_SEARCH;
                end
            end
            default: begin
                if (r_window != CODE_PREFIX) begin
                    kind     = KIND_SEARCH;
                    n_window = {r_window[15:0], i_byte};
                    n_phase  = PH_SEARCH;
                end else begin
                    kind     = KIND_CODE;
                    n_window = WINDOW_IDLE;
                    if (i_byte == CODE_END) begin
                        n_phase = PH_ENDED;
                    end else if (i_byte == CODE_PACK) begin
                        n_btg   = PACK_LEN;
                        n_phase = PH_PACK;
                    end else if (i_byte == CODE_SYSHDR) begin
                        n_phase = PH_SYS_LEN_HI;
                    end else begin
                        n_cur_id = i_byte;
                        pid      = i_byte;
                        n_phase  = PH_PKT_LEN_HI;
                    end
                end
            end
        endcase

        o_result.payload_valid    = valid;
        o_result.payload_byte     = valid ? i_byte : 8'd0;
        o_result.byte_kind        = kind;
        o_result.packet_stream_id = pid;
        o_result.last_of_packet   = last;
        o_result.stream_ended     = (n_phase == PH_ENDED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_window  <= WINDOW_IDLE;
            r_btg     <= 16'd0;
            r_hu      <= 4'd0;
            r_cur_id  <= 8'd0;
            r_aud_id  <= 8'd0;
            r_aud_set <= 1'b0;
            r_vid_id  <= 8'd0;
            r_vid_set <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_btg     <= n_btg;
            r_hu      <= n_hu;
            r_cur_id  <= n_cur_id;
            r_aud_id  <= n_aud_id;
            r_aud_set <= n_aud_set;
            r_vid_id  <= n_vid_id;
            r_vid_set <= n_vid_set;
        end
    end

endmodule

### src/msdemux_fifo.sv
`timescale 1ns / 1ps

module msdemux_fifo import msdemux_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    input  logic      i_pop,
    output t_result   o_data,
    output t_q_status o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### src/msdemux_outreg.sv
`timescale 1ns / 1ps

module msdemux_outreg import msdemux_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_stat,
    input  t_result   i_data,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_data
);

    logic    r_valid;
    t_result r_data;

    // refill whenever the register is empty or being drained this cycle
    assign o_pop   = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_data;
    end

endmodule

### src/mpeg1_system_stream_demux_top.sv
// Channel  Dir  Beat   Contents
// s_axis   in   byte   tdata[7:0] stream_byte
// m_axis   out  byte   tdata: payload_valid, payload_byte, packet_stream_id, stream_ended;
//                      tuser: byte_kind; tlast: last_of_packet
//
// One result per input byte; a byte is taken every cycle while the result
// queue has room. The parser writes each result into the queue when its input byte
// transfers; the queue loads its oldest result into the output register, which
// drives m_axis_tvalid, whenever that register is empty or being drained.
// Reset is synchronous, active low, and returns the parser to start-code search.
// Output stalls fill the queue, then s_axis_tready drops until room frees up.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mpeg1_system_stream_demux_top import msdemux_pkg::*; #(
    parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] payload_valid, [8:1] payload_byte, [16:9] packet_stream_id,
    // [17] stream_ended, [23:18] zero
    output logic [23:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // [3:0] byte_kind
    output logic        m_axis_tlast
);

    t_q_status q_stat;
    logic      q_push;
    logic      q_pop;
    t_result   push_data;
    t_result   head_data;
    t_result   out_data;

    msdemux_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_result (push_data)
    );

    msdemux_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_data  (head_data),
        .o_stat  (q_stat)
    );

    msdemux_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_data   (head_data),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (out_data)
    );

    assign m_axis_tdata = {6'd0, out_data.stream_ended, out_data.packet_stream_id,
                           out_data.payload_byte, out_data.payload_valid};
    assign m_axis_tuser = out_data.byte_kind;
    assign m_axis_tlast = out_data.last_of_packet;

    `ASSERT_IMP(a_push_room, i_clk, i_rst_n, q_push, !q_stat.full)
    `ASSERT_IMP(a_last_is_video, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
                m_axis_tuser == KIND_VIDEO && m_axis_tdata[0])
    `ASSERT_NXT(a_ended_sticks, i_clk, i_rst_n,
                m_axis_tvalid && m_axis_tready && m_axis_tdata[17],
                !m_axis_tvalid || (m_axis_tdata[17] && m_axis_tuser == KIND_ENDED))
    `ASSERT_IMP(a_pop_when_data, i_clk, i_rst_n, q_pop, !q_stat.empty)

endmodule
